// File: rtl/core/gnf_pkg.sv
// Shared types, constants and helper functions for the geohash neighbor finder.
`timescale 1ns / 1ps

package gnf_pkg;

   localparam int MaxLen = 12;
   localparam int CharW  = 8;
   localparam int CntW   = 4;
   localparam int LonW   = 31;   // longitude bits plus guard bit
   localparam int LatW   = 30;
   localparam int SymW   = 5;
   localparam int CellW  = 60;
   localparam int ShW    = 5;
   localparam int DirW   = 3;
   localparam int QDepth = 2;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_POLE     = 2'd1,
      STAT_BAD_CHAR = 2'd2,
      STAT_TOO_LONG = 2'd3
   } status_type;

   typedef enum logic [DirW-1:0] {
      DIR_SW = 3'd0,
      DIR_S  = 3'd1,
      DIR_SE = 3'd2,
      DIR_W  = 3'd3,
      DIR_E  = 3'd4,
      DIR_NW = 3'd5,
      DIR_N  = 3'd6,
      DIR_NE = 3'd7
   } dir_type;

   // One finished hash handed from the front end to the back end.
   typedef struct packed {
      logic [LonW-1:0] lon;
      logic [LatW-1:0] lat;
      logic            north;
      logic [CntW-1:0] count;
      logic [ShW-1:0]  lon_sh;
      logic [ShW-1:0]  lat_sh;
      status_type      err;
   } job_type;

   typedef struct packed {
      logic            hit;
      logic [SymW-1:0] sym;
   } sym_lookup_type;

   function automatic sym_lookup_type char_to_sym(logic [CharW-1:0] code);
      sym_lookup_type r;
      r.hit = 1'b1;
      case (code) inside
         [8'h30:8'h39]: r.sym = SymW'(code - 8'h30);          // 0..9
         [8'h62:8'h68]: r.sym = SymW'(code - 8'h62 + 8'd10);  // b..h
         8'h6a, 8'h6b:  r.sym = SymW'(code - 8'h6a + 8'd17);  // j, k
         8'h6d, 8'h6e:  r.sym = SymW'(code - 8'h6d + 8'd19);  // m, n
         [8'h70:8'h7a]: r.sym = SymW'(code - 8'h70 + 8'd21);  // p..z
         default: begin
            r.hit = 1'b0;
            r.sym = '0;
         end
      endcase
      return r;
   endfunction

   // Left shift that puts the first character's bits at the top of the field.
   function automatic logic [ShW-1:0] lon_shift(logic [CntW-1:0] n);
      logic [CntW-1:0] ev;
      logic [CntW-1:0] od;
      logic [ShW-1:0]  w;
      ev = CntW'((5'(n) + 5'd1) >> 1);
      od = n >> 1;
      w  = ShW'(ev) + ShW'(ev) + ShW'(ev) + ShW'(od) + ShW'(od);
      return ShW'(LatW) - w;
   endfunction

   function automatic logic [ShW-1:0] lat_shift(logic [CntW-1:0] n);
      logic [CntW-1:0] ev;
      logic [CntW-1:0] od;
      logic [ShW-1:0]  w;
      ev = CntW'((5'(n) + 5'd1) >> 1);
      od = n >> 1;
      w  = ShW'(ev) + ShW'(ev) + ShW'(od) + ShW'(od) + ShW'(od);
      return ShW'(LatW) - w;
   endfunction

   function automatic logic [SymW-1:0] merge_parts(logic [2:0] t, logic [1:0] w);
      return {t[2], w[1], t[1], w[0], t[0]};
   endfunction

endpackage

// File: rtl/core/geohash_neighbor_finder.sv
// Top level of the geohash neighbor finder.
//
//   channel | dir | tdata (low bit up)                      | tuser   | tlast
//   req_    | in  | char_code[7:0]                          | -       | final_char
//   rsp_    | out | direction[2:0] cell_res[62:3] len[66:63]| status  | run_end
//
// A character is taken per cycle unless the queue (up to two finished hashes) is full.
// Back end: one result per cycle while rsp_ is ready; eight per hash, one per error.
// The front end takes the next hash while the back end still walks the last one.
// Synchronous active-high reset empties the queue and clears the hash state.
// A stalled rsp_ side only blocks req_ once the queue is full.
`timescale 1ns / 1ps

module geohash_neighbor_finder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // final_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [2:0] direction, [62:3] cell_res, [66:63] length
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // run_end
);
   import gnf_pkg::*;

   job_type          front_job;
   logic             job_push;
   logic             job_full;
   job_type          head;
   logic             head_valid;
   logic             job_pop;
   logic [DirW-1:0]  o_dir;
   status_type       o_stat;
   logic [CellW-1:0] o_cell;
   logic [CntW-1:0]  o_len;

   gnf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .char_valid (req_tvalid),
      .char_ready (req_tready),
      .char_code  (req_tdata),
      .final_char (req_tlast),
      .job_push   (job_push),
      .job        (front_job),
      .job_full   (job_full)
   );

   gnf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (front_job),
      .full       (job_full),
      .pop        (job_pop),
      .head       (head),
      .head_valid (head_valid)
   );

   gnf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (job_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_dir    (o_dir),
      .out_status (o_stat),
      .out_cell   (o_cell),
      .out_len    (o_len),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, o_len, o_cell, o_dir};
   assign rsp_tuser = o_stat;

endmodule

// File: rtl/core/gnf_front.sv
// Front end: takes characters, decodes them and builds the bit strings of one hash.
`timescale 1ns / 1ps

module gnf_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      char_valid,
   output logic                      char_ready,
   input  logic [gnf_pkg::CharW-1:0] char_code,
   input  logic                      final_char,
   output logic                      job_push,
   output gnf_pkg::job_type          job,
   input  logic                      job_full
);
   import gnf_pkg::*;

   logic [LonW-1:0] lon_ff, lon_in;
   logic [LatW-1:0] lat_ff, lat_in;
   logic            north_ff, north_in;
   logic [CntW-1:0] count_ff, count_in;
   status_type      err_ff, err_in;

   logic            accept;
   logic [LonW-1:0] lon_nx;
   logic [LatW-1:0] lat_nx;
   logic            north_nx;
   logic [CntW-1:0] count_nx;
   status_type      err_nx;
   sym_lookup_type  lk;
   logic [2:0]      t;
   logic [1:0]      w;

   assign char_ready = !job_full;
   assign accept     = char_valid && char_ready;
   assign job_push   = accept && final_char;

   assign lk = char_to_sym(char_code);
   assign t  = {lk.sym[4], lk.sym[2], lk.sym[0]};
   assign w  = {lk.sym[3], lk.sym[1]};

   always_comb begin
      lon_nx   = lon_ff;
      lat_nx   = lat_ff;
      north_nx = north_ff;
      count_nx = count_ff;
      err_nx   = err_ff;
      if (count_ff >= CntW'(MaxLen)) begin
         if (err_ff == STAT_OK) begin
            err_nx = STAT_TOO_LONG;
         end
      end else begin
         if (!lk.hit) begin
            if (err_ff == STAT_OK) begin
               err_nx = STAT_BAD_CHAR;
            end
         end else if (err_ff == STAT_OK) begin
            // even positions feed the 3-bit part to longitude, odd ones to latitude
            if (!count_ff[0]) begin
               lon_nx   = {lon_ff[LonW-4:0], t};
               lat_nx   = {lat_ff[LatW-3:0], w};
               north_nx = north_ff && (w == 2'b11);
            end else begin
               lon_nx   = {lon_ff[LonW-3:0], w};
               lat_nx   = {lat_ff[LatW-4:0], t};
               north_nx = north_ff && (t == 3'b111);
            end
         end
         count_nx = count_ff + CntW'(1);
      end
   end

   always_comb begin
      job.lon    = lon_nx;
      job.lat    = lat_nx;
      job.north  = north_nx;
      job.count  = count_nx;
      job.lon_sh = lon_shift(count_nx);
      job.lat_sh = lat_shift(count_nx);
      job.err    = err_nx;
   end

   always_comb begin
      lon_in   = lon_ff;
      lat_in   = lat_ff;
      north_in = north_ff;
      count_in = count_ff;
      err_in   = err_ff;
      if (accept) begin
         if (final_char) begin
            lon_in   = LonW'(1);
            lat_in   = '0;
            north_in = 1'b1;
            count_in = '0;
            err_in   = STAT_OK;
         end else begin
            lon_in   = lon_nx;
            lat_in   = lat_nx;
            north_in = north_nx;
            count_in = count_nx;
            err_in   = err_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lon_ff   <= LonW'(1);
         lat_ff   <= '0;
         north_ff <= 1'b1;
         count_ff <= '0;
         err_ff   <= STAT_OK;
      end else begin
         lon_ff   <= lon_in;
         lat_ff   <= lat_in;
         north_ff <= north_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

endmodule

// File: rtl/core/gnf_queue.sv
// Short job queue between the front and back ends.
`timescale 1ns / 1ps

module gnf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  gnf_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output gnf_pkg::job_type head,
   output logic             head_valid
);
   import gnf_pkg::*;

   localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int FillW = $clog2(QDepth + 1);

   job_type          entry_ff [QDepth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FillW-1:0] fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (fill_ff == FillW'(QDepth));
   assign head_valid = (fill_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QDepth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QDepth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FillW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FillW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/core/gnf_back.sv
// Back end: emits a hash's eight neighbors, or one error result, each registered.
`timescale 1ns / 1ps

module gnf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  gnf_pkg::job_type          head,
   input  logic                      head_valid,
   output logic                      pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [gnf_pkg::DirW-1:0]  out_dir,
   output gnf_pkg::status_type       out_status,
   output logic [gnf_pkg::CellW-1:0] out_cell,
   output logic [gnf_pkg::CntW-1:0]  out_len,
   output logic                      out_last
);
   import gnf_pkg::*;

   dir_type          dir_ff, dir_in;
   logic             valid_ff, valid_in;
   logic [DirW-1:0]  odir_ff;
   status_type       ostat_ff;
   logic [CellW-1:0] ocell_ff;
   logic [CntW-1:0]  olen_ff;
   logic             olast_ff;

   logic             load;
   logic             is_err;
   logic             go_south, go_north, go_west, go_east;
   logic             at_pole;
   logic [LonW-1:0]  nx;
   logic [LatW-1:0]  ny;
   logic [LatW-1:0]  ax;
   logic [LatW-1:0]  ay;
   logic [CellW-1:0] nbr_bits;
   logic [DirW-1:0]  res_dir;
   status_type       res_stat;
   logic [CellW-1:0] res_cell;
   logic             res_last;

   assign load   = head_valid && (!valid_ff || out_ready);
   assign is_err = (head.err != STAT_OK);

   always_comb begin
      go_south = 1'b0;
      go_north = 1'b0;
      go_west  = 1'b0;
      go_east  = 1'b0;
      case (dir_ff)
         DIR_SW: begin
            go_south = 1'b1;
            go_west  = 1'b1;
         end
         DIR_S:  go_south = 1'b1;
         DIR_SE: begin
            go_south = 1'b1;
            go_east  = 1'b1;
         end
         DIR_W:  go_west = 1'b1;
         DIR_E:  go_east = 1'b1;
         DIR_NW: begin
            go_north = 1'b1;
            go_west  = 1'b1;
         end
         DIR_N:  go_north = 1'b1;
         DIR_NE: begin
            go_north = 1'b1;
            go_east  = 1'b1;
         end
         default: ;
      endcase
   end

   assign at_pole = (go_south && (head.lat == '0)) || (go_north && head.north);

   // guard bit above the longitude absorbs the wrap at the date line
   always_comb begin
      nx = head.lon;
      ny = head.lat;
      if (go_west) begin
         nx = head.lon - LonW'(1);
      end else if (go_east) begin
         nx = head.lon + LonW'(1);
      end
      if (go_south) begin
         ny = head.lat - LatW'(1);
      end else if (go_north) begin
         ny = head.lat + LatW'(1);
      end
   end

   assign ax = nx[LatW-1:0] << head.lon_sh;
   assign ay = ny << head.lat_sh;

   // after alignment every character owns fixed bit positions
   always_comb begin
      int lon_pos;
      int lat_pos;
      nbr_bits = '0;
      lon_pos  = LatW - 1;
      lat_pos  = LatW - 1;
      for (int i = 0; i < MaxLen; i++) begin
         if ((i % 2) == 0) begin
            nbr_bits[CellW-1-SymW*i -: SymW] = merge_parts(ax[lon_pos -: 3], ay[lat_pos -: 2]);
            lon_pos = lon_pos - 3;
            lat_pos = lat_pos - 2;
         end else begin
            nbr_bits[CellW-1-SymW*i -: SymW] = merge_parts(ay[lat_pos -: 3], ax[lon_pos -: 2]);
            lon_pos = lon_pos - 2;
            lat_pos = lat_pos - 3;
         end
      end
   end

   always_comb begin
      if (is_err) begin
         res_dir  = DIR_SW;
         res_stat = head.err;
         res_cell = '0;
         res_last = 1'b1;
      end else begin
         res_dir  = dir_ff;
         res_stat = at_pole ? STAT_POLE : STAT_OK;
         res_cell = at_pole ? '0 : nbr_bits;
         res_last = (dir_ff == DIR_NE);
      end
   end

   assign pop = load && res_last;

   always_comb begin
      dir_in   = dir_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         dir_in   = res_last ? DIR_SW : dir_type'(dir_ff + DirW'(1));
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff   <= DIR_SW;
         valid_ff <= 1'b0;
      end else begin
         dir_ff   <= dir_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         odir_ff  <= res_dir;
         ostat_ff <= res_stat;
         ocell_ff <= res_cell;
         olen_ff  <= head.count;
         olast_ff <= res_last;
      end
   end

   assign out_valid  = valid_ff;
   assign out_dir    = odir_ff;
   assign out_status = ostat_ff;
   assign out_cell   = ocell_ff;
   assign out_len    = olen_ff;
   assign out_last   = olast_ff;

endmodule

// File: sim/geohash_neighbor_checker.sv
// Geohash neighbor finder checker: watches both streams, predicts neighbors and compares.
`timescale 1ns / 1ps

module geohash_neighbor_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending
);
   import gnf_pkg::*;

   localparam logic [8*32-1:0] Base32 = "0123456789bcdefghjkmnpqrstuvwxyz";

   typedef struct packed {
      dir_type          dir;
      status_type       stat;
      logic [CellW-1:0] res;
      logic [CntW-1:0]  len;
      logic             last;
   } neighbor_type;

   neighbor_type expected_neighbors[$];

   // running decode of the hash being received
   logic [LonW-1:0] lon_acc;
   logic [LatW-1:0] lat_acc;
   logic            north_edge;
   logic [CntW-1:0] n_chars;
   status_type      hash_err;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic int symbol_value(input logic [7:0] code);
      for (int i = 0; i < 32; i++)
         if (Base32[8*(31-i) +: 8] == code)
            return i;
      return -1;
   endfunction

   function automatic logic [CellW-1:0] neighbor_cell(input logic [LonW-1:0] lon,
                                                     input logic [LatW-1:0] lat,
                                                     input int cnt, input int dx,
                                                     input int dy);
      logic [LonW-1:0]  nx;
      logic [LatW-1:0]  ny;
      logic [CellW-1:0] bits;
      logic [SymW-1:0]  sym;
      // the guard bit absorbs date-line carries and borrows
      nx   = lon + LonW'(dx);
      ny   = lat + LatW'(dy);
      bits = '0;
      for (int idx = cnt - 1; idx >= 0; idx--) begin
         if (idx % 2 == 0) begin
            sym = {nx[2], ny[1], nx[1], ny[0], nx[0]};
            nx  = nx >> 3;
            ny  = ny >> 2;
         end else begin
            sym = {ny[2], nx[1], ny[1], nx[0], ny[0]};
            nx  = nx >> 2;
            ny  = ny >> 3;
         end
         bits[55-5*idx +: 5] = sym;
      end
      return bits;
   endfunction

   task automatic clear_hash();
      lon_acc    = LonW'(1);
      lat_acc    = '0;
      north_edge = 1'b1;
      n_chars    = '0;
      hash_err   = STAT_OK;
   endtask

   task automatic absorb_char(input logic [7:0] code, input logic fin);
      int           v;
      int           k;
      int           row;
      int           col;
      logic [4:0]   s;
      logic [2:0]   t;
      logic [1:0]   w;
      neighbor_type r;
      if (n_chars >= CntW'(MaxLen)) begin
         if (hash_err == STAT_OK)
            hash_err = STAT_TOO_LONG;
      end else begin
         v = symbol_value(code);
         if (v < 0) begin
            if (hash_err == STAT_OK)
               hash_err = STAT_BAD_CHAR;
         end else if (hash_err == STAT_OK) begin
            s = v[4:0];
            t = {s[4], s[2], s[0]};
            w = {s[3], s[1]};
            if (n_chars[0] == 1'b0) begin
               lon_acc    = {lon_acc[LonW-4:0], t};
               lat_acc    = {lat_acc[LatW-3:0], w};
               north_edge = north_edge && (w == 2'b11);
            end else begin
               lon_acc    = {lon_acc[LonW-3:0], w};
               lat_acc    = {lat_acc[LatW-4:0], t};
               north_edge = north_edge && (t == 3'b111);
            end
         end
         n_chars++;
      end
      if (!fin)
         return;
      if (hash_err != STAT_OK) begin
         r.dir  = DIR_SW;
         r.stat = hash_err;
         r.res  = '0;
         r.len  = n_chars;
         r.last = 1'b1;
         expected_neighbors.push_back(r);
      end else begin
         k = 0;
         for (int m = 0; m < 9; m++) begin
            row = m / 3;
            col = m % 3;
            if (m != 4) begin
               r.dir  = dir_type'(k);
               r.len  = n_chars;
               r.last = (k == 7);
               if ((row == 0 && lat_acc == '0) || (row == 2 && north_edge)) begin
                  r.stat = STAT_POLE;
                  r.res  = '0;
               end else begin
                  r.stat = STAT_OK;
                  r.res  = neighbor_cell(lon_acc, lat_acc, int'(n_chars), col - 1, row - 1);
               end
               expected_neighbors.push_back(r);
               k++;
            end
         end
      end
      clear_hash();
   endtask

   task automatic check_result();
      neighbor_type want;
      if (expected_neighbors.size() == 0) begin
         report($sformatf("result with nothing expected, tdata %0h", rsp_tdata));
         return;
      end
      want = expected_neighbors.pop_front();
      if (rsp_tdata[2:0] !== want.dir)
         report($sformatf("direction %0d, want %0d", rsp_tdata[2:0], want.dir));
      if (rsp_tuser !== want.stat)
         report($sformatf("dir %0d status %0d, want %0d", want.dir, rsp_tuser, want.stat));
      if (rsp_tdata[62:3] !== want.res)
         report($sformatf("dir %0d cell %015h, want %015h", want.dir, rsp_tdata[62:3],
                          want.res));
      if (rsp_tdata[66:63] !== want.len)
         report($sformatf("dir %0d length %0d, want %0d", want.dir, rsp_tdata[66:63],
                          want.len));
      if (rsp_tlast !== want.last)
         report($sformatf("dir %0d last %b, want %b", want.dir, rsp_tlast, want.last));
   endtask

   // results go first: one accepted in the same cycle as a character is never its own
   always @(posedge clock) begin
      if (reset) begin
         clear_hash();
         expected_neighbors.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_result();
         if (req_tvalid && req_tready)
            absorb_char(req_tdata, req_tlast);
      end
      pending = expected_neighbors.size();
   end

endmodule

// File: sim/geohash_neighbor_finder_tb.sv
// Geohash neighbor finder testbench top: clock, reset, character stimulus and verdict.
`timescale 1ns / 1ps

module geohash_neighbor_finder_tb;
   import gnf_pkg::*;

   localparam logic [8*32-1:0] Base32 = "0123456789bcdefghjkmnpqrstuvwxyz";
   localparam int RandomChars = 280;
   localparam int CycleLimit  = 200000;
   localparam int DrainCycles = 24;

   // how a generated hash sits on one axis
   localparam int SideMin = 0;
   localparam int SideMax = 1;
   localparam int SideAny = 2;

   // receiver behavior
   localparam int ReadyAlways = 0;
   localparam int ReadyCoin   = 1;
   localparam int ReadyRare   = 2;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   int          burst_left  = 0;
   int          ready_mode  = ReadyAlways;
   int          mode_left   = 0;

   geohash_neighbor_finder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   geohash_neighbor_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: switches between always-ready, coin-flip and rarely-ready stall patterns
   initial rsp_tready = 1'b0;
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode = $urandom_range(ReadyAlways, ReadyRare);
         mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      case (ready_mode)
         ReadyAlways: rsp_tready = 1'b1;
         ReadyCoin:   rsp_tready = 1'($urandom_range(0, 1));
         default:     rsp_tready = ($urandom_range(0, 7) == 0);
      endcase
   end

   function automatic bit is_geo_char(input logic [7:0] code);
      for (int i = 0; i < 32; i++)
         if (Base32[8*(31-i) +: 8] == code)
            return 1'b1;
      return 1'b0;
   endfunction

   function automatic int pick_side();
      int r;
      r = $urandom_range(0, 5);
      return (r == 0) ? SideMin : (r == 1) ? SideMax : SideAny;
   endfunction

   // character whose longitude/latitude parts follow the chosen sides
   function automatic logic [7:0] geo_char(input int pos, input int lon_side,
                                          input int lat_side);
      int         t_side;
      int         w_side;
      logic [2:0] t;
      logic [1:0] w;
      logic [4:0] s;
      t_side = (pos % 2 == 0) ? lon_side : lat_side;
      w_side = (pos % 2 == 0) ? lat_side : lon_side;
      t = (t_side == SideMin) ? 3'd0 : (t_side == SideMax) ? 3'd7 : 3'($urandom_range(0, 7));
      w = (w_side == SideMin) ? 2'd0 : (w_side == SideMax) ? 2'd3 : 2'($urandom_range(0, 3));
      s = {t[2], w[1], t[1], w[0], t[0]};
      return Base32[8*(31-int'(s)) +: 8];
   endfunction

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_char(input logic [7:0] code, input logic fin);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid = 1'b1;
      req_tdata  = code;
      req_tlast  = fin;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic send_word(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], i == s.len() - 1);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   initial begin
      int         sent;
      int         kind;
      int         len;
      int         lon_side;
      int         lat_side;
      int         bad_pos;
      bit         paused;
      logic [7:0] code;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      sent       = 0;
      paused     = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_word("0");              // south pole row
      send_word("z");              // north pole row
      send_word("b");              // west edge, wraps over the date line
      send_word("p");              // east edge, wraps the other way
      send_word("A");              // uppercase is not in the alphabet
      send_word("{0");             // bad char first, later chars absorbed
      send_word("0123456789bcz");  // one past the longest hash
      wait_drained();

      while (sent < RandomChars) begin
         kind     = $urandom_range(0, 19);
         len      = ($urandom_range(0, 3) == 0) ? MaxLen : $urandom_range(1, MaxLen);
         lon_side = pick_side();
         lat_side = pick_side();
         bad_pos  = -1;
         if (kind < 2)
            bad_pos = $urandom_range(0, len - 1);
         else if (kind == 2)
            len = $urandom_range(MaxLen + 1, MaxLen + 4);
         for (int i = 0; i < len; i++) begin
            if (i == bad_pos) begin
               do
                  code = 8'($urandom_range(0, 255));
               while (is_geo_char(code));
            end else begin
               code = geo_char(i, lon_side, lat_side);
            end
            send_char(code, i == len - 1);
         end
         sent += len;
         if (!paused && sent >= RandomChars / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
